// File: hdl/bgc_pkg.sv
// types and constants shared by the button gesture classifier
package bgc_pkg;

   typedef logic [1:0]  req_code_type;
   typedef logic [2:0]  gesture_type;
   typedef logic [1:0]  csr_index_type;
   typedef logic [15:0] csr_data_type;
   typedef logic [31:0] time_type;

   // request codes
   localparam req_code_type REQ_SAMPLE = 2'd0;
   localparam req_code_type REQ_POLL   = 2'd1;
   localparam req_code_type REQ_RESYNC = 2'd2;

   // gesture codes
   localparam gesture_type GESTURE_NONE   = 3'd0;
   localparam gesture_type GESTURE_SHORT  = 3'd1;
   localparam gesture_type GESTURE_DOUBLE = 3'd2;
   localparam gesture_type GESTURE_LONG   = 3'd3;
   localparam gesture_type GESTURE_REPEAT = 3'd4;

   // register indexes
   localparam csr_index_type CSR_LONG_PRESS   = 2'd0;
   localparam csr_index_type CSR_DOUBLE_PRESS = 2'd1;
   localparam csr_index_type CSR_REPEAT       = 2'd2;

   // register reset values
   localparam csr_data_type LONG_PRESS_RESET   = 16'd500;
   localparam csr_data_type DOUBLE_PRESS_RESET = 16'd300;
   localparam csr_data_type REPEAT_RESET       = 16'd100;

endpackage

// File: hdl/button_gesture_classifier.sv
// button gesture classifier top level: short, double, long and repeat press detection
//
// Takes one timestamped button item per cycle while the output side does not stall, and
// returns one gesture per item. An accepted item is held in an input register, then a single
// compute stage (wrapping 32-bit subtractions and compares against the press, release and
// repeat times) updates the gesture state and loads the result register, from which the
// result is taken. The input side stalls only while the result register holds an item that
// the output side is stalling.
module button_gesture_classifier (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bgc_pkg::req_code_type req_type,
   input  logic                  req_button_down,
   input  bgc_pkg::time_type     req_now_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bgc_pkg::gesture_type  rsp_gesture,
   input  logic                  csr_write,
   input  bgc_pkg::csr_index_type csr_index,
   input  bgc_pkg::csr_data_type csr_data
);

   // configuration
   bgc_pkg::csr_data_type long_press_ff;
   bgc_pkg::csr_data_type double_press_ff;
   bgc_pkg::csr_data_type repeat_ff;

   // input register
   logic                  in_valid_ff;
   bgc_pkg::req_code_type in_type_ff;
   logic                  in_down_ff;
   bgc_pkg::time_type     in_now_ff;

   // gesture state
   logic              level_held_ff, level_held_in;
   logic              long_sent_ff, long_sent_in;
   logic              short_pending_ff, short_pending_in;
   bgc_pkg::time_type press_time_ff, press_time_in;
   bgc_pkg::time_type release_time_ff, release_time_in;
   bgc_pkg::time_type next_repeat_ff, next_repeat_in;

   // result register
   logic                 out_valid_ff;
   bgc_pkg::gesture_type gesture_ff, gesture_in;

   logic              advance;
   bgc_pkg::time_type since_press;
   bgc_pkg::time_type since_release;
   bgc_pkg::time_type since_repeat;
   bgc_pkg::time_type now_plus_repeat;
   logic              long_elapsed;
   logic              double_elapsed;
   logic              repeat_reached;
   logic              poll_fires;

   assign advance   = !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   assign rsp_valid   = out_valid_ff;
   assign rsp_gesture = gesture_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff   <= bgc_pkg::LONG_PRESS_RESET;
         double_press_ff <= bgc_pkg::DOUBLE_PRESS_RESET;
         repeat_ff       <= bgc_pkg::REPEAT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            bgc_pkg::CSR_LONG_PRESS:   long_press_ff   <= csr_data;
            bgc_pkg::CSR_DOUBLE_PRESS: double_press_ff <= csr_data;
            bgc_pkg::CSR_REPEAT:       repeat_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_type_ff <= req_type;
         in_down_ff <= req_button_down;
         in_now_ff  <= req_now_ms;
      end
   end

   // wrapping time differences
   assign since_press     = in_now_ff - press_time_ff;
   assign since_release   = in_now_ff - release_time_ff;
   assign since_repeat    = in_now_ff - next_repeat_ff;
   assign now_plus_repeat = in_now_ff + {16'd0, repeat_ff};
   assign long_elapsed    = since_press >= {16'd0, long_press_ff};
   assign double_elapsed  = since_release >= {16'd0, double_press_ff};
   assign repeat_reached  = !since_repeat[31];
   assign poll_fires      = short_pending_ff && double_elapsed;

   always_comb begin
      level_held_in    = level_held_ff;
      long_sent_in     = long_sent_ff;
      short_pending_in = short_pending_ff;
      press_time_in    = press_time_ff;
      release_time_in  = release_time_ff;
      next_repeat_in   = next_repeat_ff;
      gesture_in       = bgc_pkg::GESTURE_NONE;
      case (in_type_ff)
         bgc_pkg::REQ_SAMPLE: begin
            if (in_down_ff != level_held_ff) begin
               level_held_in = in_down_ff;
               if (in_down_ff) begin
                  press_time_in  = in_now_ff;
                  long_sent_in   = 1'b0;
                  next_repeat_in = in_now_ff;
               end else if (!long_sent_ff) begin
                  if (short_pending_ff && !double_elapsed) begin
                     short_pending_in = 1'b0;
                     gesture_in       = bgc_pkg::GESTURE_DOUBLE;
                  end else begin
                     // an unpolled pending press is dropped here
                     short_pending_in = 1'b1;
                     release_time_in  = in_now_ff;
                  end
               end
            end else if (level_held_ff && !long_sent_ff && long_elapsed) begin
               long_sent_in   = 1'b1;
               next_repeat_in = now_plus_repeat;
               gesture_in     = bgc_pkg::GESTURE_LONG;
            end else if (level_held_ff && long_sent_ff && repeat_ff != '0 && repeat_reached) begin
               next_repeat_in = now_plus_repeat;
               gesture_in     = bgc_pkg::GESTURE_REPEAT;
            end else if (poll_fires) begin
               short_pending_in = 1'b0;
               gesture_in       = bgc_pkg::GESTURE_SHORT;
            end
         end
         bgc_pkg::REQ_POLL: begin
            if (poll_fires) begin
               short_pending_in = 1'b0;
               gesture_in       = bgc_pkg::GESTURE_SHORT;
            end
         end
         bgc_pkg::REQ_RESYNC: begin
            level_held_in    = in_down_ff;
            long_sent_in     = 1'b0;
            short_pending_in = 1'b0;
            press_time_in    = in_now_ff;
            release_time_in  = in_now_ff;
            next_repeat_in   = in_now_ff;
         end
         default: ;
      endcase
   end

   // state moves only when the item leaves for the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         level_held_ff    <= 1'b0;
         long_sent_ff     <= 1'b0;
         short_pending_ff <= 1'b0;
         press_time_ff    <= '0;
         release_time_ff  <= '0;
         next_repeat_ff   <= '0;
      end else if (in_valid_ff && advance) begin
         level_held_ff    <= level_held_in;
         long_sent_ff     <= long_sent_in;
         short_pending_ff <= short_pending_in;
         press_time_ff    <= press_time_in;
         release_time_ff  <= release_time_in;
         next_repeat_ff   <= next_repeat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff && advance) begin
         gesture_ff <= gesture_in;
      end
   end

endmodule
